// ----- hw/rtl/llqm_pkg.sv -----
`default_nettype none

package llqm_pkg;

    // request field widths
    localparam int KIND_W   = 2;
    localparam int QUEUE_W  = 2;
    localparam int ENTRY_W  = 6;

    // result field widths
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 24;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERASE      = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_HERE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // latch request and launch store reads
        logic commit;   // apply updates and capture result
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [ENTRY_W-1:0]  removed_entry;
        logic                removed_valid;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  queue_count;
        logic [ENTRY_W-1:0]  front_entry;
        logic                front_valid;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/llqm_ram.sv -----
`default_nettype none

module llqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/llqm_ctrl.sv -----
`default_nettype none

module llqm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output llqm_pkg::t_cmd     o_cmd
);
    import llqm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // handshake and commands
    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_cmd.load   = i_s_tvalid && o_s_tready;
    assign o_cmd.commit = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_enters_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("request transfer did not start execution");

    a_commit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !o_cmd.load && !o_cmd.commit ||
                                !o_cmd.load)
        else $error("request taken while another executes");

endmodule

`default_nettype wire

// ----- hw/rtl/llqm_dp.sv -----
`default_nettype none

module llqm_dp #(
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_QUEUES  = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire llqm_pkg::t_cmd                  i_cmd,
    input  wire logic [llqm_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [llqm_pkg::QUEUE_W-1:0]    i_queue_id,
    input  wire logic [llqm_pkg::ENTRY_W-1:0]    i_entry_id,
    output llqm_pkg::t_result                    o_result
);
    import llqm_pkg::*;

    // only entries reachable through the entry field get storage
    localparam int REACH = 2 ** ENTRY_W;
    localparam int DEPTH = (NUM_ENTRIES < REACH) ? NUM_ENTRIES : REACH;
    localparam int EW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXW   = ENTRY_W + 1;
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    // one spare bit so the queue bound itself fits in the compare
    localparam int QXW   = ((QW > QUEUE_W) ? QW : QUEUE_W) + 1;

    // per-queue pointers and counts
    logic [EW-1:0]    r_head  [NUM_QUEUES];
    logic [EW-1:0]    r_tail  [NUM_QUEUES];
    logic [CW-1:0]    r_count [NUM_QUEUES];
    logic [DEPTH-1:0] r_queued;

    // latched request
    logic [KIND_W-1:0] r_kind;
    logic [QW-1:0]     r_q;
    logic              r_q_ok;
    logic [EW-1:0]     r_e;
    logic              r_e_ok;

    // request decode at transfer
    logic [QXW-1:0] q_ext;
    logic [QW-1:0]  q_in;
    logic           q_in_ok;
    logic           e_in_ok;
    logic [EW-1:0]  e_in;
    logic [EW-1:0]  nx_rd_addr;

    assign q_ext      = QXW'(i_queue_id);
    assign q_in_ok    = (q_ext < QXW'(NUM_QUEUES));
    assign q_in       = q_in_ok ? q_ext[QW-1:0] : '0;
    assign e_in_ok    = ({1'b0, i_entry_id} < EXW'(DEPTH));
    assign e_in       = e_in_ok ? i_entry_id[EW-1:0] : '0;
    assign nx_rd_addr = (i_kind == KIND_POP_FRONT) ? r_head[q_in] : e_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_q    <= q_in;
            r_q_ok <= q_in_ok;
            r_e    <= e_in;
            r_e_ok <= e_in_ok;
        end
    end

    // link and owner stores
    logic          nx_we, pv_we, own_we;
    logic [EW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
    logic [EW-1:0] nx_rd, pv_rd;
    logic [QW-1:0] own_rd;

    llqm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (nx_we),
        .i_wr_addr (nx_wa),
        .i_wr_data (nx_wd),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr (nx_rd_addr),
        .o_rd_data (nx_rd)
    );

    llqm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pv_we),
        .i_wr_addr (pv_wa),
        .i_wr_data (pv_wd),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr (e_in),
        .o_rd_data (pv_rd)
    );

    llqm_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_owner_ram (
        .i_clk     (i_clk),
        .i_wr_en   (own_we),
        .i_wr_addr (r_e),
        .i_wr_data (r_q),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr (e_in),
        .o_rd_data (own_rd)
    );

    // request execution
    logic [EW-1:0]       h, t, x, n_head_q, n_tail_q;
    logic [CW-1:0]       c, n_count_q;
    logic                is_empty, set_q, clr_q, do_unlink;
    logic [STATUS_W-1:0] status;

    always_comb begin
        h         = r_head[r_q];
        t         = r_tail[r_q];
        c         = r_count[r_q];
        is_empty  = (c == '0);
        n_head_q  = h;
        n_tail_q  = t;
        n_count_q = c;
        set_q     = 1'b0;
        clr_q     = 1'b0;
        do_unlink = 1'b0;
        own_we    = 1'b0;
        nx_we     = 1'b0;
        nx_wa     = r_e;
        nx_wd     = r_e;
        pv_we     = 1'b0;
        pv_wa     = r_e;
        pv_wd     = r_e;
        x         = r_e;
        status    = ST_OK;

        if (!r_q_ok) begin
            status = ST_EMPTY;
        end else begin
            case (r_kind)
                KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                    if (!r_e_ok) begin
                        status = ST_NOT_HERE;
                    end else if (r_queued[r_e]) begin
                        status = ST_QUEUED;
                    end else begin
                        set_q     = 1'b1;
                        own_we    = 1'b1;
                        n_count_q = c + 1'b1;
                        if (is_empty) begin
                            n_head_q = r_e;
                            n_tail_q = r_e;
                        end else if (r_kind == KIND_PUSH_BACK) begin
                            nx_we    = 1'b1;
                            nx_wa    = t;
                            nx_wd    = r_e;
                            pv_we    = 1'b1;
                            pv_wa    = r_e;
                            pv_wd    = t;
                            n_tail_q = r_e;
                        end else begin
                            nx_we    = 1'b1;
                            nx_wa    = r_e;
                            nx_wd    = h;
                            pv_we    = 1'b1;
                            pv_wa    = h;
                            pv_wd    = r_e;
                            n_head_q = r_e;
                        end
                    end
                end
                KIND_POP_FRONT: begin
                    if (is_empty) begin
                        status = ST_EMPTY;
                    end else begin
                        x         = h;
                        do_unlink = 1'b1;
                    end
                end
                KIND_ERASE: begin
                    if (!r_e_ok || !r_queued[r_e] || (own_rd != r_q)) begin
                        status = ST_NOT_HERE;
                    end else begin
                        do_unlink = 1'b1;
                    end
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end

        // unlink: head and tail links are implied by the pointers
        if (do_unlink) begin
            clr_q     = 1'b1;
            n_count_q = c - 1'b1;
            if (x != h) begin
                nx_we = 1'b1;
                nx_wa = pv_rd;
                nx_wd = nx_rd;
            end else begin
                n_head_q = nx_rd;
            end
            if (x != t) begin
                pv_we = 1'b1;
                pv_wa = nx_rd;
                pv_wd = pv_rd;
            end else begin
                n_tail_q = pv_rd;
            end
        end

        if (!i_cmd.commit) begin
            nx_we  = 1'b0;
            pv_we  = 1'b0;
            own_we = 1'b0;
        end
    end

    // queue state update
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_q_ok) begin
            r_head[r_q] <= n_head_q;
            r_tail[r_q] <= n_tail_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_cmd.commit && r_q_ok) begin
            r_count[r_q] <= n_count_q;
            if (set_q) begin
                r_queued[r_e] <= 1'b1;
            end
            if (clr_q) begin
                r_queued[x] <= 1'b0;
            end
        end
    end

    // result register
    logic front_ok;
    assign front_ok = r_q_ok && (n_count_q != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_result.removed_entry <= do_unlink ? ENTRY_W'(x) : '0;
            o_result.removed_valid <= do_unlink;
            o_result.status        <= status;
            o_result.queue_count   <= r_q_ok ? COUNT_W'(n_count_q) : '0;
            o_result.front_entry   <= front_ok ? ENTRY_W'(n_head_q) : '0;
            o_result.front_valid   <= front_ok;
        end
    end

    a_removed_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_unlink) |=> !r_queued[$past(x)])
        else $error("removed entry still marked as queued");

    a_inserted_joins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && set_q) |=> r_queued[$past(r_e)])
        else $error("inserted entry not marked as queued");

    a_head_is_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_q_ok && (c != '0)) |-> r_queued[h])
        else $error("front of a non-empty queue is not queued");

endmodule

`default_nettype wire

// ----- hw/rtl/linked_list_queue_manager.sv -----
`default_nettype none

// channel   dir  signals                         payload
// request   in   i_s_tvalid/o_s_tready           tuser: kind; tdata: queue_id, entry_id
// result    out  o_m_tvalid/i_m_tready           tdata: removed/status/count/front
//
// each request is taken in the transfer cycle, which launches the registered reads of
// the next, prev and owner link RAMs; execution then applies all updates and loads the
// result register once it is free; the next request is taken the cycle after that
// reset clears the queued marks and queue counts at once; no clearing pass
// a result waiting in the output register does not block the next transfer; that
// request then holds in execution until the output register is taken

module linked_list_queue_manager #(
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_QUEUES  = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [1:0] queue_id, [7:2] entry_id
    input  wire logic [llqm_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [1:0] kind
    input  wire logic [llqm_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [5:0] removed_entry, [6] removed_valid, [8:7] status, [15:9] queue_count,
    // [21:16] front_entry, [22] front_valid
    output logic [llqm_pkg::OUT_DATA_W-1:0]        o_m_tdata
);
    import llqm_pkg::*;

    t_cmd    cmd;
    t_result result;

    llqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    llqm_dp #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (i_s_tuser[KIND_W-1:0]),
        .i_queue_id (i_s_tdata[QUEUE_W-1:0]),
        .i_entry_id (i_s_tdata[QUEUE_W+ENTRY_W-1:QUEUE_W]),
        .o_result   (result)
    );

    // result packing, first field lowest
    assign o_m_tdata = {1'b0,
                        result.front_valid,
                        result.front_entry,
                        result.queue_count,
                        result.status,
                        result.removed_valid,
                        result.removed_entry};

endmodule

`default_nettype wire
